[src/cst_pkg.sv]
// Shared types and constants for the counting semaphore table.
// Holds operation codes, field widths and the lookup/update structs.
// No dependencies.
package cst_pkg;

   localparam int ID_W  = 16;
   localparam int CNT_W = 16;
   localparam int PID_W = 16;
   localparam int OP_W  = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_OPEN  = 2'd0,
      OP_WAIT  = 2'd1,
      OP_POST  = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   typedef enum logic {
      STATUS_OK  = 1'b0,
      STATUS_ERR = 1'b1
   } status_type;

   // Lookup flags from the id match table.
   typedef struct packed {
      logic hit;
      logic has_free;
   } lookup_type;

   // Entry allocation and release commands to the id match table.
   typedef struct packed {
      logic alloc;
      logic release_entry;
   } update_type;

endpackage

[src/counting_semaphore_table_core.sv]
// Counting semaphore table: top level with the count/queue-state memory and
// the waiter pid memory. Depends on cst_pkg and cst_match.
//
// Usage: a request transaction (req_*) carries an operation, a semaphore id,
// an initial count for open and the caller pid. Each request gives exactly
// one response transaction (rsp_*): status, caller_blocked, wake_valid and
// wake_pid. Requests are handled one at a time.
// Timing: the id is matched and the entry's count/queue state is read from
// memory in the accept cycle; in the next cycle (S_EXEC) the request updates
// the state and loads the response register, waiting until that register
// is free. A post that wakes a waiter dequeues in S_EXEC and reads the waiter
// pid memory; S_WAKE then loads the response into the output register.
// Stalls: a pending response waits in the output register while the next
// request is taken; it is held before its update (a waking post after it)
// until the response register frees up, so nothing is lost or reordered.
// Reset: all entries become free and the output register empties. The
// memories need no clearing pass: open initializes an entry's count and
// queue state, and a queue slot is read only after it has been written.
module counting_semaphore_table_core
   import cst_pkg::*;
#(
   parameter int NUM_SEMAPHORES = 16,
   parameter int QUEUE_DEPTH    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_operation,
   input  logic [ID_W-1:0]  req_sem_id,
   input  logic [CNT_W-1:0] req_init_value,
   input  logic [PID_W-1:0] req_caller_pid,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_status,
   output logic             rsp_caller_blocked,
   output logic             rsp_wake_valid,
   output logic [PID_W-1:0] rsp_wake_pid
);

   localparam int SLOT_W  = $clog2(NUM_SEMAPHORES);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int TOTAL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = QPTR_W + 1;
   localparam int CTRL_W  = CNT_W + QPTR_W + TOTAL_W;
   localparam int WQ_N    = NUM_SEMAPHORES * QUEUE_DEPTH;
   localparam int WADDR_W = $clog2(WQ_N);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAKE
   } state_type;

   state_type state_ff, state_in;

   // Request held for the update cycle.
   op_type             op_ff;
   logic [ID_W-1:0]    key_ff;
   logic [CNT_W-1:0]   init_ff;
   logic [PID_W-1:0]   pid_ff;
   logic               hit_ff;
   logic               free_ok_ff;
   logic [SLOT_W-1:0]  slot_ff;

   // Memories and their read data.
   logic [CTRL_W-1:0]  ctrl_mem [NUM_SEMAPHORES];
   logic [CTRL_W-1:0]  crd_ff;
   logic [PID_W-1:0]   wq_mem [WQ_N];
   logic [PID_W-1:0]   wrd_ff;

   logic               ctrl_wr_en;
   logic [CTRL_W-1:0]  ctrl_wr_data;
   logic               wq_wr_en;
   logic               wq_rd_en;
   logic [WADDR_W-1:0] wq_addr;

   // Response register.
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic               rsp_blocked_ff;
   logic               rsp_wake_valid_ff;
   logic [PID_W-1:0]   rsp_wake_pid_ff;
   logic               rsp_load;
   status_type         res_status;
   logic               res_blocked;
   logic               res_wake;
   logic [PID_W-1:0]   res_pid;

   logic               accept;
   logic               out_free;
   lookup_type         lookup;
   update_type         update;
   logic [SLOT_W-1:0]  lk_hit_slot;
   logic [SLOT_W-1:0]  lk_free_slot;

   logic [CNT_W-1:0]   cnt;
   logic [QPTR_W-1:0]  head;
   logic [TOTAL_W-1:0] tot;
   logic [SUM_W-1:0]   tail_sum;
   logic [QPTR_W-1:0]  tail_pos;
   logic [QPTR_W-1:0]  head_next;
   logic [QPTR_W-1:0]  wq_pos;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   cst_match #(
      .NUM_SEMAPHORES(NUM_SEMAPHORES)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .lookup_key  (req_sem_id),
      .lookup      (lookup),
      .hit_slot    (lk_hit_slot),
      .free_slot   (lk_free_slot),
      .update      (update),
      .update_slot (slot_ff),
      .update_key  (key_ff)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_operation);
         key_ff     <= req_sem_id;
         init_ff    <= req_init_value;
         pid_ff     <= req_caller_pid;
         hit_ff     <= lookup.hit;
         free_ok_ff <= lookup.has_free;
         slot_ff    <= lookup.hit ? lk_hit_slot : lk_free_slot;
      end
   end

   assign {cnt, head, tot} = crd_ff;

   // Queue positions: tail is head plus occupancy, wrapped once.
   always_comb begin
      tail_sum = SUM_W'(head) + SUM_W'(tot);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_pos = QPTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail_pos = QPTR_W'(tail_sum);
      end
      if (head == QPTR_W'(QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = head + QPTR_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctrl_wr_en    = 1'b0;
      ctrl_wr_data  = crd_ff;
      wq_wr_en      = 1'b0;
      wq_rd_en      = 1'b0;
      wq_pos        = tail_pos;
      update        = '0;
      rsp_load      = 1'b0;
      res_status    = STATUS_ERR;
      res_blocked   = 1'b0;
      res_wake      = 1'b0;
      res_pid       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == OP_POST && hit_ff && tot != '0) begin
               // Dequeue now, deliver the pid after the memory read.
               wq_pos       = head;
               wq_rd_en     = 1'b1;
               ctrl_wr_en   = 1'b1;
               ctrl_wr_data = {cnt, head_next, tot - TOTAL_W'(1)};
               state_in     = S_WAKE;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  OP_OPEN: begin
                     if (hit_ff) begin
                        res_status = STATUS_OK;
                     end else if (free_ok_ff) begin
                        res_status   = STATUS_OK;
                        update.alloc = 1'b1;
                        ctrl_wr_en   = 1'b1;
                        ctrl_wr_data = {init_ff, {QPTR_W{1'b0}}, {TOTAL_W{1'b0}}};
                     end
                  end
                  OP_WAIT: begin
                     if (hit_ff) begin
                        if (cnt != '0) begin
                           res_status   = STATUS_OK;
                           ctrl_wr_en   = 1'b1;
                           ctrl_wr_data = {cnt - CNT_W'(1), head, tot};
                        end else if (tot != TOTAL_W'(QUEUE_DEPTH)) begin
                           res_status   = STATUS_OK;
                           res_blocked  = 1'b1;
                           wq_wr_en     = 1'b1;
                           ctrl_wr_en   = 1'b1;
                           ctrl_wr_data = {cnt, head, tot + TOTAL_W'(1)};
                        end
                     end
                  end
                  OP_POST: begin
                     if (hit_ff) begin
                        res_status = STATUS_OK;
                        if (cnt != COUNT_MAX) begin
                           ctrl_wr_en   = 1'b1;
                           ctrl_wr_data = {cnt + CNT_W'(1), head, tot};
                        end
                     end
                  end
                  OP_CLOSE: begin
                     if (hit_ff && tot == '0) begin
                        res_status           = STATUS_OK;
                        update.release_entry = 1'b1;
                     end
                  end
                  default: begin
                     res_status = STATUS_ERR;
                  end
               endcase
            end
         end
         S_WAKE: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               res_status = STATUS_OK;
               res_wake   = 1'b1;
               res_pid    = wrd_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign wq_addr = WADDR_W'(slot_ff) * WADDR_W'(QUEUE_DEPTH) + WADDR_W'(wq_pos);

   always_ff @(posedge clock) begin
      if (ctrl_wr_en) begin
         ctrl_mem[slot_ff] <= ctrl_wr_data;
      end
      if (accept) begin
         crd_ff <= ctrl_mem[lk_hit_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (wq_wr_en) begin
         wq_mem[wq_addr] <= pid_ff;
      end
      if (wq_rd_en) begin
         wrd_ff <= wq_mem[wq_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_status_ff     <= res_status;
         rsp_blocked_ff    <= res_blocked;
         rsp_wake_valid_ff <= res_wake;
         rsp_wake_pid_ff   <= res_pid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_caller_blocked = rsp_blocked_ff;
   assign rsp_wake_valid     = rsp_wake_valid_ff;
   assign rsp_wake_pid       = rsp_wake_pid_ff;

   // An accepted transaction always moves on to its update cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted transaction did not enter update");

   // The wake cycle follows only the update cycle or itself.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAKE |-> $past(state_ff) == S_EXEC || $past(state_ff) == S_WAKE)
      else $error("wake cycle without preceding dequeue");

   // The waiter memory port does one access per cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(wq_wr_en && wq_rd_en))
      else $error("waiter memory read and write in one cycle");

   // Enqueue only into a queue that has room.
   assert property (@(posedge clock) disable iff (reset)
      wq_wr_en |-> tot != TOTAL_W'(QUEUE_DEPTH))
      else $error("enqueue into full waiter queue");

   // A response is never overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("response register overwritten");

endmodule

[src/cst_match.sv]
// Id match table: valid bits and keys of all semaphore entries.
// Finds the entry holding an id and the lowest free entry.
// Depends on cst_pkg.
module cst_match
   import cst_pkg::*;
#(
   parameter int NUM_SEMAPHORES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ID_W-1:0]                   lookup_key,
   output lookup_type                        lookup,
   output logic [$clog2(NUM_SEMAPHORES)-1:0] hit_slot,
   output logic [$clog2(NUM_SEMAPHORES)-1:0] free_slot,
   input  update_type                        update,
   input  logic [$clog2(NUM_SEMAPHORES)-1:0] update_slot,
   input  logic [ID_W-1:0]                   update_key
);

   localparam int SLOT_W = $clog2(NUM_SEMAPHORES);

   logic [NUM_SEMAPHORES-1:0] valid_ff;
   logic [ID_W-1:0]           key_ff [NUM_SEMAPHORES];
   logic [NUM_SEMAPHORES-1:0] match;

   always_comb begin
      for (int i = 0; i < NUM_SEMAPHORES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == lookup_key);
      end
   end

   // Lowest matching and lowest free entry.
   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_slot = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
      lookup.hit      = |match;
      lookup.has_free = ~&valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (update.alloc) begin
         valid_ff[update_slot] <= 1'b1;
      end else if (update.release_entry) begin
         valid_ff[update_slot] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update.alloc) begin
         key_ff[update_slot] <= update_key;
      end
   end

endmodule

[tb/sv/tb_counting_semaphore_table_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for counting_semaphore_table_core: drives request
// transactions and checks every response against a built-in semaphore table model.
// Depends on cst_pkg and the counting_semaphore_table_core RTL.
module tb_counting_semaphore_table_core;
   import cst_pkg::*;

   localparam int NUM_SEMAPHORES = 16;
   localparam int QUEUE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 1850;
   localparam int POOL_SIZE      = 20;

   typedef struct packed {
      logic             status;
      logic             caller_blocked;
      logic             wake_valid;
      logic [PID_W-1:0] wake_pid;
   } sem_result_type;

   // Mirror of the semaphore table; predicts one response per request.
   class sem_table_scoreboard;
      bit               used [NUM_SEMAPHORES];
      bit [ID_W-1:0]    key [NUM_SEMAPHORES];
      bit [CNT_W-1:0]   count [NUM_SEMAPHORES];
      bit [PID_W-1:0]   ring [NUM_SEMAPHORES][QUEUE_DEPTH];
      int               head [NUM_SEMAPHORES];
      int               total [NUM_SEMAPHORES];
      sem_result_type   expected_q[$];
      int               error_count;

      function new();
         foreach (used[i]) begin
            used[i]  = 1'b0;
            head[i]  = 0;
            total[i] = 0;
         end
         error_count = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(op_type op, bit [ID_W-1:0] id, bit [CNT_W-1:0] init,
                                 bit [PID_W-1:0] pid);
         sem_result_type res;
         int             slot;
         int             spare;
         slot  = -1;
         spare = -1;
         res   = '0;
         res.status = STATUS_ERR;
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            if (used[i] && key[i] == id && slot < 0) slot = i;
            if (!used[i] && spare < 0) spare = i;
         end
         case (op)
            OP_OPEN: begin
               if (slot >= 0) begin
                  res.status = STATUS_OK;
               end else if (spare >= 0) begin
                  used[spare]  = 1'b1;
                  key[spare]   = id;
                  count[spare] = init;
                  head[spare]  = 0;
                  total[spare] = 0;
                  res.status   = STATUS_OK;
               end
            end
            OP_WAIT: begin
               if (slot >= 0) begin
                  if (count[slot] != 0) begin
                     count[slot] = count[slot] - 1'b1;
                     res.status  = STATUS_OK;
                  end else if (total[slot] < QUEUE_DEPTH) begin
                     ring[slot][(head[slot] + total[slot]) % QUEUE_DEPTH] = pid;
                     total[slot]++;
                     res.caller_blocked = 1'b1;
                     res.status         = STATUS_OK;
                  end
               end
            end
            OP_POST: begin
               if (slot >= 0) begin
                  if (total[slot] > 0) begin
                     res.wake_valid = 1'b1;
                     res.wake_pid   = ring[slot][head[slot]];
                     head[slot]     = (head[slot] + 1) % QUEUE_DEPTH;
                     total[slot]--;
                  end else if (count[slot] != COUNT_MAX) begin
                     count[slot] = count[slot] + 1'b1;
                  end
                  res.status = STATUS_OK;
               end
            end
            OP_CLOSE: begin
               if (slot >= 0 && total[slot] == 0) begin
                  used[slot] = 1'b0;
                  res.status = STATUS_OK;
               end
            end
            default: begin
               res.status = STATUS_ERR;
            end
         endcase
         expected_q.push_back(res);
      endfunction

      function void check_response(sem_result_type got);
         sem_result_type exp;
         if (expected_q.size() == 0) begin
            $error("response transaction with no request pending");
            error_count++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            error_count++;
         end
         if (got.caller_blocked !== exp.caller_blocked) begin
            $error("caller_blocked: expected %0d, actual %0d",
                   exp.caller_blocked, got.caller_blocked);
            error_count++;
         end
         if (got.wake_valid !== exp.wake_valid) begin
            $error("wake_valid: expected %0d, actual %0d", exp.wake_valid, got.wake_valid);
            error_count++;
         end
         if (got.wake_pid !== exp.wake_pid) begin
            $error("wake_pid: expected %0h, actual %0h", exp.wake_pid, got.wake_pid);
            error_count++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [OP_W-1:0]  req_operation;
   logic [ID_W-1:0]  req_sem_id;
   logic [CNT_W-1:0] req_init_value;
   logic [PID_W-1:0] req_caller_pid;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_status;
   logic             rsp_caller_blocked;
   logic             rsp_wake_valid;
   logic [PID_W-1:0] rsp_wake_pid;

   sem_table_scoreboard sb;
   bit                  steady;
   logic [ID_W-1:0]     id_pool [POOL_SIZE];

   counting_semaphore_table_core #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .QUEUE_DEPTH    (QUEUE_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_sem_id         (req_sem_id),
      .req_init_value     (req_init_value),
      .req_caller_pid     (req_caller_pid),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_caller_blocked (rsp_caller_blocked),
      .rsp_wake_valid     (rsp_wake_valid),
      .rsp_wake_pid       (rsp_wake_pid)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the response side at random, except during the steady stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !reset && (steady || $urandom_range(0, 99) >= 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_status, rsp_caller_blocked, rsp_wake_valid, rsp_wake_pid});
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic issue_request(op_type op, logic [ID_W-1:0] id, logic [CNT_W-1:0] init,
                                logic [PID_W-1:0] pid);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(0, 99) < 24) gap++;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_operation  = op;
      req_sem_id     = id;
      req_init_value = init;
      req_caller_pid = pid;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, id, init, pid);
      @(negedge clock);
   endtask

   task automatic random_op(logic [ID_W-1:0] id);
      int               r;
      op_type           op;
      logic [CNT_W-1:0] init;
      r  = $urandom_range(0, 99);
      op = (r < 25) ? OP_OPEN : (r < 60) ? OP_WAIT : (r < 85) ? OP_POST : OP_CLOSE;
      r  = $urandom_range(0, 99);
      if (r < 70)      init = CNT_W'($urandom_range(0, 3));
      else if (r < 80) init = COUNT_MAX;
      else if (r < 90) init = COUNT_MAX - 1'b1;
      else             init = CNT_W'($urandom_range(0, 65535));
      issue_request(op, id, init, PID_W'($urandom_range(0, 65535)));
   endtask

   initial begin
      int               sent;
      int               burst;
      int               guard;
      int               r;
      logic [ID_W-1:0]  id;
      sb             = new();
      steady         = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_OPEN;
      req_sem_id     = '0;
      req_init_value = '0;
      req_caller_pid = '0;
      foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 65535));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Unknown ids, saturation, existing open, blocking and wakeup order, busy close.
      issue_request(OP_WAIT,  16'h0000, 16'h0000, 16'h1234);
      issue_request(OP_POST,  16'hFFFF, 16'hFFFF, 16'hFFFF);
      issue_request(OP_CLOSE, 16'h5555, 16'h0000, 16'h0000);
      issue_request(OP_OPEN,  16'hFFFF, 16'hFFFF, 16'h0000);
      issue_request(OP_POST,  16'hFFFF, 16'h0000, 16'h0000);
      issue_request(OP_OPEN,  16'hFFFF, 16'h0003, 16'h0000);
      issue_request(OP_WAIT,  16'hFFFF, 16'h0000, 16'hAAAA);
      issue_request(OP_OPEN,  16'h0000, 16'h0000, 16'h0000);
      issue_request(OP_WAIT,  16'h0000, 16'hAAAA, 16'hFFFF);
      issue_request(OP_WAIT,  16'h0000, 16'h5555, 16'h0000);
      issue_request(OP_CLOSE, 16'h0000, 16'h0000, 16'h0000);
      issue_request(OP_POST,  16'h0000, 16'h0000, 16'h0000);
      issue_request(OP_POST,  16'h0000, 16'h0000, 16'h0000);
      issue_request(OP_POST,  16'h0000, 16'h0000, 16'h0000);
      issue_request(OP_WAIT,  16'h0000, 16'h0000, 16'h5555);
      issue_request(OP_CLOSE, 16'h0000, 16'h0000, 16'h0000);
      issue_request(OP_CLOSE, 16'hFFFF, 16'h0000, 16'h0000);
      issue_request(OP_OPEN,  16'hAAAA, 16'h5555, 16'h0000);
      issue_request(OP_CLOSE, 16'hAAAA, 16'h0000, 16'h0000);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 700 && sent < 1000);
         r = $urandom_range(0, 99);
         id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (r < 5) begin
            // Try to overrun the waiter queue, then drain it past empty.
            burst = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
            issue_request(OP_OPEN, id, CNT_W'($urandom_range(0, 2)),
                          PID_W'($urandom_range(0, 65535)));
            repeat (burst) issue_request(OP_WAIT, id, CNT_W'($urandom_range(0, 65535)),
                                         PID_W'($urandom_range(0, 65535)));
            repeat (burst) issue_request(OP_POST, id, CNT_W'($urandom_range(0, 65535)),
                                         PID_W'($urandom_range(0, 65535)));
            issue_request(OP_CLOSE, id, '0, '0);
            sent += 2 * burst + 2;
         end else if (r < 13) begin
            issue_request(op_type'($urandom_range(0, 3)), ID_W'($urandom_range(0, 65535)),
                          CNT_W'($urandom_range(0, 65535)), PID_W'($urandom_range(0, 65535)));
            sent++;
         end else begin
            random_op(id);
            sent++;
         end
      end
      steady    = 1'b0;
      req_valid = 1'b0;

      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
         sb.error_count++;
      end
      if (sb.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
src/cst_pkg.sv
src/cst_match.sv
src/counting_semaphore_table_core.sv
tb/sv/tb_counting_semaphore_table_core.sv
